[src/layer_pixel_blend_with_feather_core_assert.svh]
// ---------------------------------------------------------------------------
// Layer pixel blend assertion macros
// Shared property forms for the layer blend core checks.
// ---------------------------------------------------------------------------
`ifndef LAYER_PIXEL_BLEND_WITH_FEATHER_CORE_ASSERT_SVH
`define LAYER_PIXEL_BLEND_WITH_FEATHER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define LPBF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpbf check failed");

// A condition that holds in every cycle outside reset.
`define LPBF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lpbf check failed");

`endif

[src/lpbf_pkg.sv]
// ---------------------------------------------------------------------------
// Layer pixel blend package
// Types, constants and helper functions of the layer blend core.
// ---------------------------------------------------------------------------
package lpbf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 11;
  localparam int NSTG      = 10;

  localparam logic [16:0] ONE_Q  = 17'd65536;
  localparam logic [15:0] HALF_Q = 16'd32768;

  typedef enum logic [1:0] {
    MAP_HEIGHT  = 2'd0,
    MAP_CONTROL = 2'd1,
    MAP_COLOR   = 2'd2,
    MAP_UNUSED  = 2'd3
  } map_kind_t;

  typedef enum logic [1:0] {
    BLEND_SUM    = 2'd0,
    BLEND_SUB    = 2'd1,
    BLEND_LERP   = 2'd2,
    BLEND_UNUSED = 2'd3
  } blend_kind_t;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_MAP      = 3'd1,
    REG_BLEND    = 3'd2,
    REG_STRENGTH = 3'd3,
    REG_FEATHER  = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6,
    REG_NONE     = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [3:0][31:0] src;
    logic [3:0][31:0] dst;
    logic [16:0]      alpha;
    logic             active;
    logic             fone;
  } item_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] quo;
  } div_t;

  // Four restoring division steps; the dividend bits shifted in are zero.
  function automatic div_t div4(input logic [15:0] r, input logic [15:0] q,
                                input logic [14:0] fw);
    logic [15:0] rr;
    logic [15:0] qq;
    div_t        res;
    rr = r;
    qq = q;
    for (int k = 0; k < 4; k++) begin
      rr = {rr[14:0], 1'b0};
      if (rr >= {1'b0, fw}) begin
        rr = rr - {1'b0, fw};
        qq = {qq[14:0], 1'b1};
      end else begin
        qq = {qq[14:0], 1'b0};
      end
    end
    res.rem = rr;
    res.quo = qq;
    return res;
  endfunction

endpackage

[src/layer_pixel_blend_with_feather_core.sv]
// ---------------------------------------------------------------------------
// Layer pixel blend with feather core
// Blends one source pixel into one destination pixel per clock.
// ---------------------------------------------------------------------------
// Each accepted word yields one result word, and a new word may start in every
// cycle, so busy never rises. The pipeline is a four-stage feather divider
// followed by the smoothstep, mask, strength and channel multiply stages.
// The receiver cannot stall, so the strobe simply follows the pipeline.
// Configuration is written through cfg_valid/cfg_ready and must only change
// while no words are in flight.
module layer_pixel_blend_with_feather_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] src_red,
  input  logic signed [31:0] src_green,
  input  logic signed [31:0] src_blue,
  input  logic signed [31:0] src_alpha,
  input  logic signed [31:0] dst_red,
  input  logic signed [31:0] dst_green,
  input  logic signed [31:0] dst_blue,
  input  logic signed [31:0] dst_alpha,
  input  logic        [16:0] mask_weight_in,
  input  logic        [11:0] pos_x,
  input  logic        [11:0] pos_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data,
  output logic               strobe,
  output logic signed [31:0] out_red,
  output logic signed [31:0] out_green,
  output logic signed [31:0] out_blue,
  output logic signed [31:0] out_alpha
);
  import lpbf_pkg::*;

  logic        enable;
  map_kind_t   map_kind;
  blend_kind_t blend_kind;
  logic [19:0] strength;
  logic [14:0] feather_width;
  logic [12:0] layer_width;
  logic [12:0] layer_height;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      map_kind      <= MAP_HEIGHT;
      blend_kind    <= BLEND_SUM;
      strength      <= 20'd65536;
      feather_width <= 15'd0;
      layer_width   <= 13'd1;
      layer_height  <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        REG_ENABLE:   enable        <= cfg_data[0];
        REG_MAP:      map_kind      <= map_kind_t'(cfg_data[1:0]);
        REG_BLEND:    blend_kind    <= blend_kind_t'(cfg_data[1:0]);
        REG_STRENGTH: strength      <= cfg_data[19:0];
        REG_FEATHER:  feather_width <= cfg_data[14:0];
        REG_WIDTH:    layer_width   <= cfg_data[12:0];
        REG_HEIGHT:   layer_height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Entry stage: border distance and the feather shortcut.
  logic [12:0] dx0, dx1, dy0, dy1, dxm, dym, dmin;
  logic [20:0] dshift;
  item_t       in_item;

  always_comb begin
    dx0    = {1'b0, pos_x};
    dx1    = layer_width - 13'd1 - {1'b0, pos_x};
    dy0    = {1'b0, pos_y};
    dy1    = layer_height - 13'd1 - {1'b0, pos_y};
    dxm    = (dx0 < dx1) ? dx0 : dx1;
    dym    = (dy0 < dy1) ? dy0 : dy1;
    dmin   = (dxm < dym) ? dxm : dym;
    dshift = {dmin, 8'd0};
    in_item.src    = {src_alpha, src_blue, src_green, src_red};
    in_item.dst    = {dst_alpha, dst_blue, dst_green, dst_red};
    in_item.alpha  = mask_weight_in;
    in_item.active = enable && ({1'b0, pos_x} < layer_width) &&
                     ({1'b0, pos_y} < layer_height) && (map_kind != MAP_UNUSED);
    in_item.fone   = (feather_width == 15'd0) ||
                     (dshift >= {6'd0, feather_width});
  end

  item_t       pl [NSTG];
  logic [NSTG-1:0] vld;
  logic [15:0] dv_rem [4];
  logic [15:0] dv_quo [5];
  div_t        dv_nx  [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTG-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    pl[0]     <= in_item;
    dv_rem[0] <= dshift[15:0];
    dv_quo[0] <= 16'd0;
    for (int k = 1; k < NSTG; k++) begin
      pl[k] <= pl[k-1];
    end
    for (int k = 0; k < 3; k++) begin
      dv_rem[k+1] <= dv_nx[k].rem;
    end
    for (int k = 0; k < 4; k++) begin
      dv_quo[k+1] <= dv_nx[k].quo;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dv_nx[k] = div4(dv_rem[k], dv_quo[k], feather_width);
    end
  end

  // Smoothstep, mask and strength stages.
  logic [31:0] sq;
  logic [17:0] poly;
  logic [32:0] sq_rnd;
  logic [34:0] prod2;
  logic [35:0] p2_rnd;
  logic [16:0] fw_w;
  logic [33:0] mprod;
  logic [34:0] m_rnd;
  logic [16:0] mask_w;
  logic [36:0] aprod;
  logic [37:0] a_rnd;
  logic [20:0] add_w;
  logic [16:0] rep_w;

  always_comb begin
    sq_rnd = {1'b0, sq} + {17'd0, HALF_Q};
    p2_rnd = {1'b0, prod2} + {20'd0, HALF_Q};
    fw_w   = pl[6].fone ? ONE_Q : p2_rnd[32:16];
    m_rnd  = {1'b0, mprod} + {19'd0, HALF_Q};
    mask_w = (m_rnd[34:16] > {2'd0, ONE_Q}) ? ONE_Q : m_rnd[32:16];
    a_rnd  = {1'b0, aprod} + {22'd0, HALF_Q};
    add_w  = a_rnd[36:16];
    rep_w  = (add_w > {4'd0, ONE_Q}) ? ONE_Q : add_w[16:0];
  end

  always_ff @(posedge clk) begin
    sq    <= dv_quo[4] * dv_quo[4];
    poly  <= 18'd196608 - {1'b0, dv_quo[4], 1'b0};
    prod2 <= sq_rnd[32:16] * poly;
    mprod <= pl[6].alpha * fw_w;
    aprod <= mask_w * strength;
  end

  // Channel multiply and final add/clamp.
  logic signed [53:0] cprod [4];
  logic signed [53:0] cprod_nx [4];
  logic signed [32:0] diff;
  logic signed [53:0] crnd;
  logic signed [37:0] delta;
  logic signed [38:0] rsum;
  logic signed [31:0] dsel;
  logic [3:0][31:0]   res;
  logic               lane_on;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff = 33'(signed'(pl[8].src[i])) - 33'(signed'(pl[8].dst[i]));
      if (blend_kind == BLEND_LERP) begin
        cprod_nx[i] = 54'(diff * signed'({1'b0, rep_w}));
      end else begin
        cprod_nx[i] = 54'(signed'(pl[8].src[i]) * signed'({1'b0, add_w}));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      cprod[i] <= cprod_nx[i];
    end
  end

  always_comb begin
    res = pl[9].dst;
    for (int i = 0; i < 4; i++) begin
      dsel    = signed'(pl[9].dst[i]);
      crnd    = cprod[i] + 54'(signed'({1'b0, HALF_Q}));
      delta   = crnd[53:16];
      lane_on = (map_kind == MAP_COLOR) || (i == 0);
      if (blend_kind == BLEND_SUB) begin
        rsum = 39'(dsel) - 39'(delta);
      end else begin
        rsum = 39'(dsel) + 39'(delta);
      end
      if ((map_kind == MAP_COLOR) && (blend_kind != BLEND_LERP)) begin
        if (rsum < 39'sd0) begin
          rsum = 39'sd0;
        end else if (rsum > 39'(signed'({1'b0, ONE_Q}))) begin
          rsum = 39'(signed'({1'b0, ONE_Q}));
        end
      end else begin
        if (rsum > 39'sd2147483647) begin
          rsum = 39'sd2147483647;
        end else if (rsum < -39'sd2147483648) begin
          rsum = -39'sd2147483648;
        end
      end
      if (pl[9].active && lane_on) begin
        res[i] = rsum[31:0];
      end
    end
    if (pl[9].active && (map_kind != MAP_COLOR)) begin
      res[3] = {15'd0, ONE_Q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= res[0];
    out_green <= res[1];
    out_blue  <= res[2];
    out_alpha <= res[3];
  end

`include "layer_pixel_blend_with_feather_core_assert.svh"

  `LPBF_ASSERT_ALWAYS(a_never_busy, !busy)
  `LPBF_ASSERT_IMPL(a_strobe_follows, vld[NSTG-1], ##1 strobe)
  `LPBF_ASSERT_IMPL(a_no_spurious, !vld[NSTG-1], ##1 !strobe)

endmodule

[test/layer_pixel_blend_with_feather_core_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Layer pixel blend with feather core testbench
// Drives pixel words through the core under a series of register settings,
// predicts every blended pixel from its own fixed-point model and checks each
// strobed result, channel by channel, against the oldest prediction.
// ---------------------------------------------------------------------------
module layer_pixel_blend_with_feather_core_tb;
  import lpbf_pkg::*;

  typedef struct packed {
    logic [3:0][31:0] src;
    logic [3:0][31:0] dst;
    logic [16:0]      mask;
    logic [11:0]      px;
    logic [11:0]      py;
  } pixel_t;

  typedef logic [3:0][31:0] rgba_t;

  localparam int WATCHDOG = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] src_red = '0, src_green = '0, src_blue = '0, src_alpha = '0;
  logic signed [31:0] dst_red = '0, dst_green = '0, dst_blue = '0, dst_alpha = '0;
  logic [16:0] mask_weight_in = '0;
  logic [11:0] pos_x = '0, pos_y = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        strobe;
  logic signed [31:0] out_red, out_green, out_blue, out_alpha;

  layer_pixel_blend_with_feather_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue),
    .src_alpha(src_alpha), .dst_red(dst_red), .dst_green(dst_green),
    .dst_blue(dst_blue), .dst_alpha(dst_alpha), .mask_weight_in(mask_weight_in),
    .pos_x(pos_x), .pos_y(pos_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic        m_enable = 1'b1;
  map_kind_t   m_map = MAP_HEIGHT;
  blend_kind_t m_blend = BLEND_SUM;
  logic [19:0] m_strength = 20'd65536;
  logic [14:0] m_feather = '0;
  logic [12:0] m_width = 13'd1;
  logic [12:0] m_height = 13'd1;

  pixel_t pending_pixels[$];
  rgba_t  blended_expect[$];
  int     errors = 0;
  bit     gaps_on = 1'b1;
  int     quiet_cycles = 0;

  function automatic longint mul_round(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint feather_gain(longint x, longint y);
    longint d, t, s;
    if (m_feather == 0) return 65536;
    d = x;
    if (m_width - 1 - x < d) d = m_width - 1 - x;
    if (y < d) d = y;
    if (m_height - 1 - y < d) d = m_height - 1 - y;
    if ((d << 8) >= m_feather) return 65536;
    t = (d << 24) / m_feather;
    s = (t * t + 32768) >> 16;
    return (s * (3 * 65536 - 2 * t) + 32768) >> 16;
  endfunction

  function automatic rgba_t blend_pixel(pixel_t p);
    longint src[4], dst[4];
    longint mask, add_w, rep_w, r, delta;
    int nch;
    rgba_t res;
    for (int i = 0; i < 4; i++) begin
      src[i] = longint'($signed(p.src[i]));
      dst[i] = longint'($signed(p.dst[i]));
    end
    if (m_enable && p.px < m_width && p.py < m_height && m_map != MAP_UNUSED) begin
      mask = mul_round(longint'(p.mask), feather_gain(p.px, p.py));
      if (mask > 65536) mask = 65536;
      add_w = mul_round(mask, longint'(m_strength));
      rep_w = add_w > 65536 ? 65536 : add_w;
      nch = (m_map == MAP_COLOR) ? 4 : 1;
      for (int i = 0; i < nch; i++) begin
        if (m_blend == BLEND_LERP) begin
          r = clip(dst[i] + mul_round(src[i] - dst[i], rep_w),
                   -64'sd2147483648, 64'sd2147483647);
        end else begin
          delta = mul_round(src[i], add_w);
          r = (m_blend == BLEND_SUB) ? dst[i] - delta : dst[i] + delta;
          if (m_map == MAP_COLOR) r = clip(r, 0, 65536);
          else r = clip(r, -64'sd2147483648, 64'sd2147483647);
        end
        dst[i] = r;
      end
      if (m_map != MAP_COLOR) dst[3] = 65536;
    end
    for (int i = 0; i < 4; i++) res[i] = dst[i][31:0];
    return res;
  endfunction

  // Driver: holds start while words wait, with random bursts of idle cycles.
  int     gap_left = 0;
  pixel_t cur_pixel;
  always @(posedge clk) begin
    bit take;
    bit next_start;
    take = start && !busy;
    if (!rst) begin
      if (take) blended_expect.push_back(blend_pixel(cur_pixel));
      if (!start || take) begin
        next_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pixels.size() > 0) begin
          cur_pixel = pending_pixels.pop_front();
          src_red <= cur_pixel.src[0];
          src_green <= cur_pixel.src[1];
          src_blue <= cur_pixel.src[2];
          src_alpha <= cur_pixel.src[3];
          dst_red <= cur_pixel.dst[0];
          dst_green <= cur_pixel.dst[1];
          dst_blue <= cur_pixel.dst[2];
          dst_alpha <= cur_pixel.dst[3];
          mask_weight_in <= cur_pixel.mask;
          pos_x <= cur_pixel.px;
          pos_y <= cur_pixel.py;
          next_start = 1'b1;
          if (gaps_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 13);
        end
        start <= next_start;
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest prediction.
  always @(posedge clk) begin
    rgba_t want;
    rgba_t got;
    string names[4];
    names = '{"out_red", "out_green", "out_blue", "out_alpha"};
    if (!rst && strobe) begin
      got = {out_alpha, out_blue, out_green, out_red};
      if (blended_expect.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        want = blended_expect.pop_front();
        for (int i = 0; i < 4; i++)
          if (want[i] !== got[i]) begin
            $error("%s expected %h actual %h", names[i], want[i], got[i]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("layer_pixel_blend_with_feather_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:   m_enable = v[0];
      REG_MAP:      m_map = map_kind_t'(v[1:0]);
      REG_BLEND:    m_blend = blend_kind_t'(v[1:0]);
      REG_STRENGTH: m_strength = v[19:0];
      REG_FEATHER:  m_feather = v[14:0];
      REG_WIDTH:    m_width = v[12:0];
      REG_HEIGHT:   m_height = v[12:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_pixels.size() != 0 || start || gap_left != 0 ||
           blended_expect.size() != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_chan();
    logic [31:0] picks[4];
    picks = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h10000};
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 65536);
      2: return picks[$urandom_range(0, 3)];
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    for (int i = 0; i < 4; i++) begin
      p.src[i] = rand_chan();
      p.dst[i] = rand_chan();
    end
    case ($urandom_range(0, 9))
      0: p.mask = 17'($urandom);
      1: p.mask = 17'd65536;
      2: p.mask = 17'd0;
      default: p.mask = 17'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 9) == 0 || m_width == 0 || m_height == 0) begin
      p.px = 12'($urandom);
      p.py = 12'($urandom);
    end else begin
      p.px = 12'($urandom_range(0, m_width > 4096 ? 4095 : m_width - 1));
      p.py = 12'($urandom_range(0, m_height > 4096 ? 4095 : m_height - 1));
    end
    return p;
  endfunction

  function automatic logic [12:0] rand_dim();
    case ($urandom_range(0, 7))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'd0;
      3: return 13'($urandom);
      default: return 13'($urandom_range(2, 200));
    endcase
  endfunction

  initial begin
    pixel_t p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    p = '0;
    p.src = {32'h10000, 32'h8000, 32'h4000, 32'h2000};
    p.dst = {32'h1000, 32'h2000, 32'h3000, 32'h4000};
    p.mask = 17'd65536;
    pending_pixels.push_back(p);
    p.px = 12'd1;
    pending_pixels.push_back(p);
    drain();

    write_reg(REG_WIDTH, 32'd4096);
    write_reg(REG_HEIGHT, 32'd4096);
    write_reg(REG_FEATHER, 32'd16384);
    write_reg(REG_STRENGTH, 32'd655360);
    foreach (p.src[i]) begin
      p.src[i] = 32'h7fffffff;
      p.dst[i] = 32'h7fff0000;
    end
    p.mask = 17'h1ffff;
    p.px = 12'd4095; p.py = 12'd2048;
    pending_pixels.push_back(p);
    p.px = 12'd64; p.py = 12'd64;
    pending_pixels.push_back(p);
    p.px = 12'd2000; p.py = 12'd3;
    pending_pixels.push_back(p);
    drain();

    write_reg(REG_BLEND, BLEND_SUB);
    foreach (p.src[i]) p.src[i] = 32'h7fffffff;
    foreach (p.dst[i]) p.dst[i] = 32'h80000000;
    pending_pixels.push_back(p);
    drain();

    write_reg(REG_MAP, MAP_COLOR);
    write_reg(REG_FEATHER, 32'd0);
    for (int b = 0; b < 4; b++) begin
      write_reg(REG_BLEND, blend_kind_t'(b));
      pending_pixels.push_back(rand_pixel());
      pending_pixels.push_back(rand_pixel());
      drain();
    end

    write_reg(REG_MAP, MAP_UNUSED);
    pending_pixels.push_back(rand_pixel());
    drain();
    write_reg(REG_MAP, MAP_CONTROL);
    write_reg(REG_STRENGTH, 32'd0);
    pending_pixels.push_back(rand_pixel());
    drain();
    write_reg(REG_ENABLE, 32'd0);
    pending_pixels.push_back(rand_pixel());
    drain();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_WIDTH, 32'd0);
    pending_pixels.push_back(rand_pixel());
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_ENABLE, ($urandom_range(0, 7) != 0));
      write_reg(REG_MAP, $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
      write_reg(REG_BLEND, $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
      case ($urandom_range(0, 4))
        0: write_reg(REG_STRENGTH, 32'd655360);
        1: write_reg(REG_STRENGTH, 32'd0);
        2: write_reg(REG_STRENGTH, $urandom);
        default: write_reg(REG_STRENGTH, $urandom_range(0, 655360));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_FEATHER, 32'd0);
        1: write_reg(REG_FEATHER, 32'd16384);
        2: write_reg(REG_FEATHER, $urandom);
        default: write_reg(REG_FEATHER, $urandom_range(1, 4096));
      endcase
      if (ph == 0) begin
        write_reg(REG_WIDTH, 32'd4096);
        write_reg(REG_HEIGHT, 32'd4096);
      end else begin
        write_reg(REG_WIDTH, rand_dim());
        write_reg(REG_HEIGHT, rand_dim());
      end
      gaps_on = (ph < 8);
      for (int n = 0; n < 100; n++) pending_pixels.push_back(rand_pixel());
      drain();
    end

    if (errors == 0 && blended_expect.size() == 0)
      $display("layer_pixel_blend_with_feather_core verification clean");
    else
      $display("layer_pixel_blend_with_feather_core verification failed");
    $finish;
  end

endmodule

[layer_pixel_blend_with_feather_core.f]
+incdir+src
src/lpbf_pkg.sv
src/layer_pixel_blend_with_feather_core.sv
test/layer_pixel_blend_with_feather_core_tb.sv
